[sv/dsri_pkg.sv]
// ----------------------------------------------------------------------------
// dsri_pkg
// Shared types and constants of the Doppler spectrum RGB integrator.
// ----------------------------------------------------------------------------
package dsri_pkg;

    localparam int WAVE_W  = 16;   // Q12.4 wavelength
    localparam int VAL_W   = 24;   // Q3.20 power and responses
    localparam int RATIO_W = 18;   // Q2.16 Doppler ratio
    localparam int GRID_W  = 18;   // shifted wavelength, Q14.4
    localparam int STEP_W  = 19;   // signed difference of two grid points
    localparam int NUM_W   = 44;   // interpolation numerator, signed
    localparam int MAG_W   = 43;   // magnitude of the numerator
    localparam int SUM_W   = 64;   // accumulator width
    localparam int FLR_W   = 28;   // floor(resp * power / 2^20)
    localparam int PROD_W  = 47;   // floored product times step

    localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd65536;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic {
        KIND_STORE,
        KIND_DROP
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic                    last;
        logic [WAVE_W-1:0]       wave;
        logic signed [VAL_W-1:0] power;
        logic signed [VAL_W-1:0] red;
        logic signed [VAL_W-1:0] green;
        logic signed [VAL_W-1:0] blue;
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SH_RD,
        ST_SH_WR,
        ST_MG_RD,
        ST_MG_SEL,
        ST_SC_RD,
        ST_SC_CHK,
        ST_VL_RD0,
        ST_VL_RD1,
        ST_VL_CAP,
        ST_IP_SET,
        ST_IP_DIV,
        ST_IP_WAIT,
        ST_AC_M1,
        ST_AC_M2,
        ST_AC_ADD,
        ST_DONE
    } t_bstate;

endpackage

[sv/dsri_fifo.sv]
// ----------------------------------------------------------------------------
// dsri_fifo
// Short command queue between the front and the back of the integrator.
// ----------------------------------------------------------------------------
module dsri_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0]              r_mem [dsri_pkg::FIFO_DEPTH];
    logic [dsri_pkg::FIFO_AW-1:0]  r_wp;
    logic [dsri_pkg::FIFO_AW-1:0]  r_rp;
    logic [dsri_pkg::FIFO_AW:0]    r_cnt;
    logic                          push_ok;
    logic                          pop_ok;

    assign o_full  = (r_cnt == (dsri_pkg::FIFO_AW + 1)'(dsri_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (pop_ok)  r_rp <= r_rp + 1'b1;
            if (push_ok && !pop_ok)      r_cnt <= r_cnt + 1'b1;
            else if (!push_ok && pop_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_data;
    end

endmodule

[sv/dsri_front.sv]
// ----------------------------------------------------------------------------
// dsri_front
// Accepts sample transactions, counts them and classifies each as stored or
// dropped before it enters the command queue.
// ----------------------------------------------------------------------------
module dsri_front #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 i_full,
    input  logic [dsri_pkg::WAVE_W-1:0]          i_wave_length,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_spectral_power,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_red_response,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_green_response,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_blue_response,
    input  logic                                 i_last_sample,
    output logic                                 o_stall,
    output logic                                 o_push,
    output dsri_pkg::t_cmd                       o_cmd,
    output logic [$clog2(MAX_SAMPLES)-1:0]       o_addr
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          drop;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign drop    = (r_cnt == CW'(MAX_SAMPLES));
    assign o_addr  = r_cnt[AW-1:0];

    always_comb begin
        o_cmd.kind  = drop ? dsri_pkg::KIND_DROP : dsri_pkg::KIND_STORE;
        o_cmd.last  = i_last_sample;
        o_cmd.wave  = i_wave_length;
        o_cmd.power = i_spectral_power;
        o_cmd.red   = i_red_response;
        o_cmd.green = i_green_response;
        o_cmd.blue  = i_blue_response;
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_last_sample) n_cnt = '0;
            else if (!drop)    n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[sv/dsri_div.sv]
// ----------------------------------------------------------------------------
// dsri_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsri_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dsri_pkg::MAG_W-1:0]    i_dividend,
    input  logic [dsri_pkg::GRID_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [dsri_pkg::MAG_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(dsri_pkg::MAG_W + 1);

    logic [dsri_pkg::GRID_W-1:0] r_rem;
    logic [dsri_pkg::GRID_W-1:0] r_den;
    logic [dsri_pkg::MAG_W-1:0]  r_quo;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [dsri_pkg::GRID_W:0]   sh;
    logic [dsri_pkg::GRID_W:0]   sub;
    logic                        ge;

    assign sh  = {r_rem, r_quo[dsri_pkg::MAG_W-1]};
    assign sub = sh - {1'b0, r_den};
    assign ge  = (sh >= {1'b0, r_den});

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
            r_cnt <= CNT_W'(dsri_pkg::MAG_W);
        end else if (r_busy) begin
            r_rem <= ge ? sub[dsri_pkg::GRID_W-1:0] : sh[dsri_pkg::GRID_W-1:0];
            r_quo <= {r_quo[dsri_pkg::MAG_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

[sv/dsri_back.sv]
// ----------------------------------------------------------------------------
// dsri_back
// Holds the sample stores, shifts the grid, walks the merged grid,
// interpolates and accumulates the three channels.
// ----------------------------------------------------------------------------
module dsri_back #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [dsri_pkg::RATIO_W-1:0]         i_ratio,
    input  logic                                 i_empty,
    input  dsri_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(MAX_SAMPLES)-1:0]       i_addr,
    output logic                                 o_pop,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic signed [dsri_pkg::SUM_W-1:0]    o_red_sum,
    output logic signed [dsri_pkg::SUM_W-1:0]    o_green_sum,
    output logic signed [dsri_pkg::SUM_W-1:0]    o_blue_sum,
    output logic                                 o_saturated
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int GW = dsri_pkg::GRID_W;
    localparam int VW = dsri_pkg::VAL_W;
    localparam int SW = dsri_pkg::SUM_W;

    // Stores
    logic [dsri_pkg::WAVE_W-1:0] r_wave_mem  [MAX_SAMPLES];
    logic [GW-1:0]               r_shift_mem [MAX_SAMPLES];
    logic signed [VW-1:0]        r_pow_mem   [MAX_SAMPLES];
    logic signed [VW-1:0]        r_red_mem   [MAX_SAMPLES];
    logic signed [VW-1:0]        r_grn_mem   [MAX_SAMPLES];
    logic signed [VW-1:0]        r_blu_mem   [MAX_SAMPLES];

    logic [dsri_pkg::WAVE_W-1:0] r_wave_rd;
    logic [GW-1:0]               r_shift_rd;
    logic signed [VW-1:0]        r_pow_rd;
    logic signed [VW-1:0]        r_red_rd;
    logic signed [VW-1:0]        r_grn_rd;
    logic signed [VW-1:0]        r_blu_rd;

    logic          store_we;
    logic          shift_we;
    logic [AW-1:0] a_wave;
    logic [AW-1:0] a_shift;
    logic [AW-1:0] a_pow;
    logic [AW-1:0] a_rgb;

    // Control and working registers
    dsri_pkg::t_bstate r_state, n_state;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_m, n_m;
    logic              r_first, n_first;
    logic [GW-1:0]     r_p, n_p;
    logic [GW-1:0]     r_prev, n_prev;
    logic signed [dsri_pkg::STEP_W-1:0] r_step, n_step;
    logic              r_fw, n_fw, r_xw, n_xw, r_fs, n_fs, r_xs, n_xs;
    logic [AW-1:0]     r_idx_w, n_idx_w, r_idx_s, n_idx_s;
    logic [GW-1:0]     r_glo_w, n_glo_w, r_ghi_w, n_ghi_w;
    logic [GW-1:0]     r_glo_s, n_glo_s, r_ghi_s, n_ghi_s;
    logic [GW-1:0]     r_gwp, n_gwp, r_gsp, n_gsp;
    logic signed [VW-1:0] r_vhi [4];
    logic signed [VW-1:0] n_vhi [4];
    logic signed [VW-1:0] r_vlo [4];
    logic signed [VW-1:0] n_vlo [4];
    logic signed [VW-1:0] r_res [4];
    logic signed [VW-1:0] n_res [4];
    logic [1:0]        r_c, n_c;
    logic signed [dsri_pkg::NUM_W-1:0]  r_num, n_num;
    logic              r_neg, n_neg;
    logic signed [dsri_pkg::FLR_W-1:0]  r_f, n_f;
    logic signed [dsri_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [SW-1:0] r_acc [3];
    logic signed [SW-1:0] n_acc [3];
    logic              r_sat, n_sat;
    logic              r_lost, n_lost;
    logic              r_out_valid, n_out_valid;
    logic signed [SW-1:0] r_out_r, n_out_r, r_out_g, n_out_g, r_out_b, n_out_b;
    logic              r_out_sat, n_out_sat;

    // Datapath terms
    logic [33:0]       sh_prod;
    logic [GW-1:0]     sh_val;
    logic [GW-1:0]     wv;
    logic [GW-1:0]     sv;
    logic              iv, jv;
    logic              take_w_only, take_s_only;
    logic [GW-1:0]     mg_p;
    logic              eq_w, in_w, eq_s, in_s;
    logic              hit_w, hit_s;
    logic              sel_found, sel_exact;
    logic [GW-1:0]     sel_glo, sel_ghi;
    logic signed [VW:0] diff;
    logic [GW-1:0]     dp;
    logic signed [dsri_pkg::NUM_W-1:0] num_prod;
    logic [dsri_pkg::MAG_W-1:0] num_mag;
    logic [GW-1:0]     den;
    logic              div_start;
    logic              div_done;
    logic [dsri_pkg::MAG_W-1:0] div_quo;
    logic signed [VW:0] qs;
    logic signed [VW+1:0] ip_sum;
    logic signed [47:0] m1;
    logic signed [dsri_pkg::PROD_W-1:0] m2;
    logic signed [SW-1:0] add_a, add_b, add_s;
    logic              add_ovf;

    assign sh_prod = 34'(r_wave_rd) * 34'(i_ratio);
    assign sh_val  = sh_prod[33:16];

    assign wv = GW'(r_wave_rd);
    assign sv = r_shift_rd;
    assign iv = (r_i < r_n);
    assign jv = (r_j < r_n);
    assign take_w_only = !jv || (iv && wv < sv);
    assign take_s_only = !take_w_only && (!iv || sv < wv);
    assign mg_p = take_s_only ? sv : wv;

    assign eq_w  = (wv == r_p);
    assign in_w  = (r_m != '0) && (r_gwp < r_p) && (r_p < wv);
    assign eq_s  = (sv == r_p);
    assign in_s  = (r_m != '0) && (r_gsp < r_p) && (r_p < sv);
    assign hit_w = !r_fw && (eq_w || in_w);
    assign hit_s = !r_fs && (eq_s || in_s);

    assign sel_found = (r_c == 2'd0) ? r_fs : r_fw;
    assign sel_exact = (r_c == 2'd0) ? r_xs : r_xw;
    assign sel_glo   = (r_c == 2'd0) ? r_glo_s : r_glo_w;
    assign sel_ghi   = (r_c == 2'd0) ? r_ghi_s : r_ghi_w;
    assign diff      = (VW+1)'(r_vhi[r_c]) - (VW+1)'(r_vlo[r_c]);
    assign dp        = r_p - sel_glo;
    assign num_prod  = dsri_pkg::NUM_W'(diff) * dsri_pkg::NUM_W'($signed({1'b0, dp}));
    assign num_mag   = r_num[dsri_pkg::NUM_W-1] ? dsri_pkg::MAG_W'(-r_num)
                                                : r_num[dsri_pkg::MAG_W-1:0];
    assign den       = sel_ghi - sel_glo;
    assign div_start = (r_state == dsri_pkg::ST_IP_DIV);
    assign qs        = r_neg ? -$signed(div_quo[VW:0]) : $signed(div_quo[VW:0]);
    assign ip_sum    = (VW+2)'(r_vlo[r_c]) + (VW+2)'(qs);

    assign m1    = 48'(r_res[r_c + 2'd1]) * 48'(r_res[0]);
    assign m2    = dsri_pkg::PROD_W'(r_f) * dsri_pkg::PROD_W'(r_step);
    assign add_a = r_acc[r_c];
    assign add_b = SW'(r_prod);
    assign add_s = add_a + add_b;
    assign add_ovf = (add_a[SW-1] == add_b[SW-1]) && (add_s[SW-1] != add_a[SW-1]);

    dsri_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid     = r_out_valid;
    assign o_red_sum   = r_out_r;
    assign o_green_sum = r_out_g;
    assign o_blue_sum  = r_out_b;
    assign o_saturated = r_out_sat;

    always_comb begin
        n_state = r_state;
        n_n = r_n; n_i = r_i; n_j = r_j; n_m = r_m;
        n_first = r_first; n_p = r_p; n_prev = r_prev; n_step = r_step;
        n_fw = r_fw; n_xw = r_xw; n_fs = r_fs; n_xs = r_xs;
        n_idx_w = r_idx_w; n_idx_s = r_idx_s;
        n_glo_w = r_glo_w; n_ghi_w = r_ghi_w; n_glo_s = r_glo_s; n_ghi_s = r_ghi_s;
        n_gwp = r_gwp; n_gsp = r_gsp;
        n_vhi = r_vhi; n_vlo = r_vlo; n_res = r_res;
        n_c = r_c; n_num = r_num; n_neg = r_neg; n_f = r_f; n_prod = r_prod;
        n_acc = r_acc; n_sat = r_sat; n_lost = r_lost;
        n_out_valid = r_out_valid;
        n_out_r = r_out_r; n_out_g = r_out_g; n_out_b = r_out_b; n_out_sat = r_out_sat;
        o_pop    = 1'b0;
        store_we = 1'b0;
        shift_we = 1'b0;
        a_wave   = '0;
        a_shift  = '0;
        a_pow    = '0;
        a_rgb    = '0;

        if (r_out_valid && !i_stall) n_out_valid = 1'b0;

        unique case (r_state)
            dsri_pkg::ST_IDLE: begin
                if (!i_empty && !(i_cmd.last && r_out_valid)) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == dsri_pkg::KIND_STORE) store_we = 1'b1;
                    else n_lost = 1'b1;
                    if (i_cmd.last) begin
                        n_n = (i_cmd.kind == dsri_pkg::KIND_STORE) ?
                              CW'(i_addr) + 1'b1 : CW'(MAX_SAMPLES);
                        n_m     = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_first = 1'b1;
                        n_sat   = 1'b0;
                        n_acc[0] = '0;
                        n_acc[1] = '0;
                        n_acc[2] = '0;
                        n_state = dsri_pkg::ST_SH_RD;
                    end
                end
            end
            dsri_pkg::ST_SH_RD: begin
                a_wave  = r_m[AW-1:0];
                n_state = dsri_pkg::ST_SH_WR;
            end
            dsri_pkg::ST_SH_WR: begin
                shift_we = 1'b1;
                n_m = r_m + 1'b1;
                n_state = (r_m + 1'b1 == r_n) ? dsri_pkg::ST_MG_RD : dsri_pkg::ST_SH_RD;
            end
            dsri_pkg::ST_MG_RD: begin
                a_wave  = iv ? r_i[AW-1:0] : '0;
                a_shift = jv ? r_j[AW-1:0] : '0;
                n_state = (!iv && !jv) ? dsri_pkg::ST_DONE : dsri_pkg::ST_MG_SEL;
            end
            dsri_pkg::ST_MG_SEL: begin
                n_p    = mg_p;
                n_prev = mg_p;
                if (!take_s_only) n_i = r_i + 1'b1;
                if (!take_w_only) n_j = r_j + 1'b1;
                if (r_first) begin
                    n_first = 1'b0;
                    n_state = dsri_pkg::ST_MG_RD;
                end else begin
                    n_step  = $signed({1'b0, mg_p}) - $signed({1'b0, r_prev});
                    n_m     = '0;
                    n_fw    = 1'b0; n_xw = 1'b0; n_fs = 1'b0; n_xs = 1'b0;
                    n_idx_w = '0;   n_idx_s = '0;
                    n_state = dsri_pkg::ST_SC_RD;
                end
            end
            dsri_pkg::ST_SC_RD: begin
                a_wave  = r_m[AW-1:0];
                a_shift = r_m[AW-1:0];
                n_state = dsri_pkg::ST_SC_CHK;
            end
            dsri_pkg::ST_SC_CHK: begin
                // The first grid entry that matches the point, or that closes
                // an open interval around it, decides that grid's value.
                if (hit_w) begin
                    n_fw = 1'b1; n_xw = eq_w; n_idx_w = r_m[AW-1:0];
                    n_glo_w = r_gwp; n_ghi_w = wv;
                end
                if (hit_s) begin
                    n_fs = 1'b1; n_xs = eq_s; n_idx_s = r_m[AW-1:0];
                    n_glo_s = r_gsp; n_ghi_s = sv;
                end
                n_gwp = wv;
                n_gsp = sv;
                n_m   = r_m + 1'b1;
                if (((r_fw || hit_w) && (r_fs || hit_s)) || (r_m + 1'b1 == r_n))
                    n_state = dsri_pkg::ST_VL_RD0;
                else
                    n_state = dsri_pkg::ST_SC_RD;
            end
            dsri_pkg::ST_VL_RD0: begin
                a_pow   = r_idx_s;
                a_rgb   = r_idx_w;
                n_state = dsri_pkg::ST_VL_RD1;
            end
            dsri_pkg::ST_VL_RD1: begin
                n_vhi[0] = r_pow_rd; n_vhi[1] = r_red_rd;
                n_vhi[2] = r_grn_rd; n_vhi[3] = r_blu_rd;
                a_pow   = (r_idx_s == '0) ? '0 : r_idx_s - 1'b1;
                a_rgb   = (r_idx_w == '0) ? '0 : r_idx_w - 1'b1;
                n_state = dsri_pkg::ST_VL_CAP;
            end
            dsri_pkg::ST_VL_CAP: begin
                n_vlo[0] = r_pow_rd; n_vlo[1] = r_red_rd;
                n_vlo[2] = r_grn_rd; n_vlo[3] = r_blu_rd;
                n_c     = 2'd0;
                n_state = dsri_pkg::ST_IP_SET;
            end
            dsri_pkg::ST_IP_SET: begin
                if (!sel_found || sel_exact) begin
                    n_res[r_c] = sel_found ? r_vhi[r_c] : '0;
                    n_c = r_c + 2'd1;
                    n_state = (r_c == 2'd3) ? dsri_pkg::ST_AC_M1 : dsri_pkg::ST_IP_SET;
                end else begin
                    n_num   = num_prod;
                    n_state = dsri_pkg::ST_IP_DIV;
                end
            end
            dsri_pkg::ST_IP_DIV: begin
                n_neg   = r_num[dsri_pkg::NUM_W-1];
                n_state = dsri_pkg::ST_IP_WAIT;
            end
            dsri_pkg::ST_IP_WAIT: begin
                if (div_done) begin
                    n_res[r_c] = ip_sum[VW-1:0];
                    n_c = r_c + 2'd1;
                    n_state = (r_c == 2'd3) ? dsri_pkg::ST_AC_M1 : dsri_pkg::ST_IP_SET;
                end
            end
            dsri_pkg::ST_AC_M1: begin
                n_f     = m1[47:20];
                n_state = dsri_pkg::ST_AC_M2;
            end
            dsri_pkg::ST_AC_M2: begin
                n_prod  = m2;
                n_state = dsri_pkg::ST_AC_ADD;
            end
            dsri_pkg::ST_AC_ADD: begin
                if (add_ovf) begin
                    n_sat = 1'b1;
                    n_acc[r_c] = add_b[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
                end else begin
                    n_acc[r_c] = add_s;
                end
                if (r_c == 2'd2) begin
                    n_c = 2'd0;
                    n_state = dsri_pkg::ST_MG_RD;
                end else begin
                    n_c = r_c + 2'd1;
                    n_state = dsri_pkg::ST_AC_M1;
                end
            end
            dsri_pkg::ST_DONE: begin
                n_out_valid = 1'b1;
                n_out_r     = r_acc[0];
                n_out_g     = r_acc[1];
                n_out_b     = r_acc[2];
                n_out_sat   = r_sat || r_lost;
                n_lost      = 1'b0;
                n_state     = dsri_pkg::ST_IDLE;
            end
            default: n_state = dsri_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsri_pkg::ST_IDLE;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lost      <= n_lost;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_i <= n_i; r_j <= n_j; r_m <= n_m;
        r_first <= n_first; r_p <= n_p; r_prev <= n_prev; r_step <= n_step;
        r_fw <= n_fw; r_xw <= n_xw; r_fs <= n_fs; r_xs <= n_xs;
        r_idx_w <= n_idx_w; r_idx_s <= n_idx_s;
        r_glo_w <= n_glo_w; r_ghi_w <= n_ghi_w; r_glo_s <= n_glo_s; r_ghi_s <= n_ghi_s;
        r_gwp <= n_gwp; r_gsp <= n_gsp;
        r_vhi <= n_vhi; r_vlo <= n_vlo; r_res <= n_res;
        r_c <= n_c; r_num <= n_num; r_neg <= n_neg; r_f <= n_f; r_prod <= n_prod;
        r_acc <= n_acc; r_sat <= n_sat;
        r_out_r <= n_out_r; r_out_g <= n_out_g; r_out_b <= n_out_b;
        r_out_sat <= n_out_sat;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_wave_mem[i_addr] <= i_cmd.wave;
            r_pow_mem[i_addr]  <= i_cmd.power;
            r_red_mem[i_addr]  <= i_cmd.red;
            r_grn_mem[i_addr]  <= i_cmd.green;
            r_blu_mem[i_addr]  <= i_cmd.blue;
        end
        r_wave_rd <= r_wave_mem[a_wave];
        r_pow_rd  <= r_pow_mem[a_pow];
        r_red_rd  <= r_red_mem[a_rgb];
        r_grn_rd  <= r_grn_mem[a_rgb];
        r_blu_rd  <= r_blu_mem[a_rgb];
    end

    always_ff @(posedge i_clk) begin
        if (shift_we) r_shift_mem[r_m[AW-1:0]] <= sh_val;
        r_shift_rd <= r_shift_mem[a_shift];
    end

endmodule

[sv/doppler_spectrum_rgb_integrator_core.sv]
// ----------------------------------------------------------------------------
// doppler_spectrum_rgb_integrator_core
// Integrates a Doppler-shifted spectrum against red, green and blue responses.
// ----------------------------------------------------------------------------
// Samples arrive one transaction each and are taken at up to one per cycle
// while the queue has room; every sample passes through the command queue
// before it is written to the stores, and a sample beyond MAX_SAMPLES is
// dropped and flagged. The transaction that carries last_sample starts the
// computation, which is one sequencer working through stores with one read
// port each. For n stored samples it first shifts the grid, reading and
// writing each entry in turn; then for each of the up to 2n merged points it
// merges, scans up to n grid entries, reads the values, runs up to four
// interpolations on the shared one-bit-per-cycle divider, and multiplies and
// accumulates the three channels. Only the one result of the spectrum leaves
// the block, from an output register; while the computation runs, the next
// spectrum's samples fill the four-entry queue and then stall.
// ----------------------------------------------------------------------------
module doppler_spectrum_rgb_integrator_core #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dsri_pkg::RATIO_W-1:0]         i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [dsri_pkg::WAVE_W-1:0]          i_wave_length,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_spectral_power,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_red_response,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_green_response,
    input  logic signed [dsri_pkg::VAL_W-1:0]    i_blue_response,
    input  logic                                 i_last_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dsri_pkg::SUM_W-1:0]    o_red_sum,
    output logic signed [dsri_pkg::SUM_W-1:0]    o_green_sum,
    output logic signed [dsri_pkg::SUM_W-1:0]    o_blue_sum,
    output logic                                 o_saturated
);

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int CMD_W  = $bits(dsri_pkg::t_cmd);
    localparam int FIFO_W = CMD_W + AW;

    // The Doppler ratio must be written only while the block is idle; the block itself does not enforce this.
    logic [dsri_pkg::RATIO_W-1:0] r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= dsri_pkg::RATIO_RESET;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_data;
        end
    end

    logic            push;
    dsri_pkg::t_cmd  front_cmd;
    logic [AW-1:0]   front_addr;
    logic            fifo_full;
    logic            fifo_empty;
    logic            pop;
    logic [FIFO_W-1:0] fifo_out;
    dsri_pkg::t_cmd  back_cmd;
    logic [AW-1:0]   back_addr;

    dsri_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_full           (fifo_full),
        .i_wave_length    (i_wave_length),
        .i_spectral_power (i_spectral_power),
        .i_red_response   (i_red_response),
        .i_green_response (i_green_response),
        .i_blue_response  (i_blue_response),
        .i_last_sample    (i_last_sample),
        .o_stall          (o_stall),
        .o_push           (push),
        .o_cmd            (front_cmd),
        .o_addr           (front_addr)
    );

    // Each queue entry carries the classified sample and its store address.
    dsri_fifo #(.WIDTH(FIFO_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_addr, front_cmd}),
        .i_pop   (pop),
        .o_data  (fifo_out),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    assign back_cmd  = dsri_pkg::t_cmd'(fifo_out[CMD_W-1:0]);
    assign back_addr = fifo_out[FIFO_W-1 -: AW];

    dsri_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ratio     (r_ratio),
        .i_empty     (fifo_empty),
        .i_cmd       (back_cmd),
        .i_addr      (back_addr),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_red_sum   (o_red_sum),
        .o_green_sum (o_green_sum),
        .o_blue_sum  (o_blue_sum),
        .o_saturated (o_saturated)
    );

endmodule
